[rtl/rgb_to_hsi_pixel_defines.svh]
// assertion macros for the rgb to hsi pixel converter checker
// depends on hsi_pkg for the pipeline latency
`ifndef RGB_TO_HSI_PIXEL_DEFINES_SVH
`define RGB_TO_HSI_PIXEL_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define HSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property checked when the request made at the trigger comes out
`define HSI_ASSERT_LAT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##(hsi_pkg::PipeLat) (cons)) else $error(msg);

`endif

[rtl/hsi_pkg.sv]
// shared types, constants and the hue threshold table of the rgb to hsi converter
// no dependencies
package hsi_pkg;

  localparam int HueSteps = 127;
  localparam int HueBits  = 7;
  localparam int DivSteps = 54;
  localparam int HueLat   = 17;
  localparam int PipeLat  = 61;
  localparam int HueDly   = PipeLat - HueLat;
  localparam int IntRecip = 683;
  localparam int IntShift = 11;

  typedef logic [HueBits-1:0] hidx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
  } pix_out_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] sq;
  } hue_ent_t;

  typedef hue_ent_t [HueSteps:0] hue_rom_t;

  // shift and subtract quotient and remainder, quotient in the upper half
  function automatic logic [127:0] divmod64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  // cos of each threshold angle by taylor series in q58, stored as sign and q62 square
  function automatic hue_rom_t build_hue_rom();
    hue_rom_t           rom;
    logic [63:0]        num;
    logic [63:0]        part;
    logic [63:0]        rest;
    logic [63:0]        ang;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic [63:0]        dv;
    logic signed [63:0] acc;
    logic [127:0]       p;
    logic [127:0]       qr;
    rom = '0;
    for (int k = 1; k <= HueSteps; k++) begin
      num  = 64'(157 * k);
      qr   = divmod64(num << 29, 64'd6375);
      part = qr[127:64];
      rest = qr[63:0];
      qr   = divmod64(rest << 29, 64'd6375);
      ang  = (part << 29) + qr[127:64];
      p    = 128'(ang) * 128'(ang);
      a2   = p[121:58];
      term = 64'd1 << 58;
      acc  = $signed(term);
      for (int i = 1; i < 40; i++) begin
        p    = 128'(term) * 128'(a2);
        dv   = 64'((2 * i - 1) * (2 * i));
        qr   = divmod64(p[121:58], dv);
        term = qr[127:64];
        if ((i & 1) != 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      rom[k].neg = acc[63];
      mag = acc[63] ? 64'(-acc) : 64'(acc);
      p = 128'(mag) * 128'(mag);
      rom[k].sq = p[117:54];
    end
    return rom;
  endfunction

  localparam hue_rom_t HueRom = build_hue_rom();

endpackage

[rtl/hsi_hue.sv]
// hue pipeline: angle terms, then a seven step binary search of the threshold table
// depends on hsi_pkg
module hsi_hue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hsi_pkg::pix_in_t pixel_i,
  output logic             valid_o,
  output logic [7:0]       hue_o
);

  typedef struct packed {
    logic [17:0]     d;
    logic [15:0]     nsq;
    logic            nneg;
    logic            bgt;
    logic            dz;
    hsi_pkg::hidx_t  cur;
  } srch_t;

  typedef struct packed {
    srch_t           st;
    logic            neg;
    hsi_pkg::hidx_t  cand;
    logic [49:0]     plo;
    logic [49:0]     phi;
  } prod_t;

  // stage 1: differences and products
  logic               v1_q;
  logic signed [17:0] xx_q, xy_q, yy_q;
  logic signed [8:0]  n_q;
  logic               bgt1_q;

  logic signed [8:0]  x, y;
  logic signed [9:0]  xpy, nn;
  logic signed [17:0] xx_d, xy_d, yy_d;

  always_comb begin
    x    = $signed({1'b0, pixel_i.red}) - $signed({1'b0, pixel_i.green});
    y    = $signed({1'b0, pixel_i.red}) - $signed({1'b0, pixel_i.blue});
    xpy  = 10'(x) + 10'(y);
    nn   = $signed(xpy + $signed({9'b0, xpy[9]})) >>> 1;
    xx_d = x * x;
    xy_d = x * y;
    yy_d = y * y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q   <= xx_d;
    xy_q   <= xy_d;
    yy_q   <= yy_d;
    n_q    <= nn[8:0];
    bgt1_q <= pixel_i.blue > pixel_i.green;
  end

  // stage 2: denominator square and numerator square
  logic  sv_q [hsi_pkg::HueBits+1];
  srch_t st_q [hsi_pkg::HueBits+1];
  srch_t st0_d;
  logic signed [19:0] ds;
  logic [8:0]         nabs;

  always_comb begin
    ds          = 20'(xx_q) - 20'(xy_q) + 20'(yy_q);
    nabs        = n_q[8] ? 9'(-n_q) : 9'(n_q);
    st0_d.d     = ds[17:0];
    st0_d.nsq   = 16'(nabs[7:0] * nabs[7:0]);
    st0_d.nneg  = n_q[8];
    st0_d.bgt   = bgt1_q;
    st0_d.dz    = ds[17:0] == 18'd0;
    st0_d.cur   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
  end

  // search steps: product stage then compare stage
  logic  pv_q [hsi_pkg::HueBits];
  prod_t pr_q [hsi_pkg::HueBits];

  for (genvar j = 0; j < hsi_pkg::HueBits; j++) begin : gen_step
    prod_t             pr_d;
    hsi_pkg::hue_ent_t ent;
    srch_t             nx_d;
    logic [81:0]       rr, ll;
    logic              hit;

    always_comb begin
      pr_d.st   = st_q[j];
      pr_d.cand = st_q[j].cur | (hsi_pkg::hidx_t'(1) << (hsi_pkg::HueBits - 1 - j));
      ent       = hsi_pkg::HueRom[pr_d.cand];
      pr_d.neg  = ent.neg;
      pr_d.plo  = 50'(ent.sq[31:0]) * 50'(st_q[j].d);
      pr_d.phi  = 50'(ent.sq[63:32]) * 50'(st_q[j].d);
    end

    always_comb begin
      rr = {pr_q[j].phi, 32'b0} + 82'(pr_q[j].plo);
      ll = {4'b0, pr_q[j].st.nsq, 62'b0};
      if (pr_q[j].st.nneg) begin
        hit = !pr_q[j].neg || (ll >= rr);
      end else begin
        hit = !pr_q[j].neg && (ll <= rr);
      end
      nx_d = pr_q[j].st;
      if (hit) begin
        nx_d.cur = pr_q[j].cand;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[j]   <= 1'b0;
        sv_q[j+1] <= 1'b0;
      end else begin
        pv_q[j]   <= sv_q[j];
        sv_q[j+1] <= pv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      pr_q[j]   <= pr_d;
      st_q[j+1] <= nx_d;
    end
  end

  // output stage
  logic       vo_q;
  logic [7:0] hue_q, hue_d;
  srch_t      fin;

  always_comb begin
    fin = st_q[hsi_pkg::HueBits];
    if (fin.dz) begin
      hue_d = 8'd0;
    end else if (fin.bgt) begin
      hue_d = 8'd254 - {1'b0, fin.cur};
    end else begin
      hue_d = {1'b0, fin.cur};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= sv_q[hsi_pkg::HueBits];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
  end

  assign valid_o = vo_q;
  assign hue_o   = hue_q;

endmodule

[rtl/hsi_sat.sv]
// saturation pipeline: bit serial quotient stages and double rounding steps
// depends on hsi_pkg
module hsi_sat (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hsi_pkg::pix_in_t pixel_i,
  output logic             valid_o,
  output logic [7:0]       sat_o
);

  typedef struct packed {
    logic [10:0] rem;
    logic [9:0]  b;
    logic [53:0] q;
    logic [3:0]  k;
    logic        sp;
    logic [7:0]  spv;
  } divs_t;

  // stage 1: sum, three times minimum, special cases
  logic       v1_q;
  logic [9:0] a1_q, b1_q;
  logic       sp1_q;
  logic [7:0] spv1_q;
  logic [9:0] s_d, a_d;
  logic [7:0] mn;

  always_comb begin
    mn = pixel_i.blue;
    if (mn > pixel_i.green) begin
      mn = pixel_i.green;
    end
    if (mn > pixel_i.red) begin
      mn = pixel_i.red;
    end
    s_d = 10'(pixel_i.red) + 10'(pixel_i.green) + 10'(pixel_i.blue);
    a_d = 10'(mn) * 10'd3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= a_d;
    b1_q   <= s_d;
    sp1_q  <= (s_d == 10'd0) || (mn == 8'd0) || (a_d >= s_d);
    spv1_q <= ((s_d != 10'd0) && (mn == 8'd0)) ? 8'd255 : 8'd0;
  end

  // stage 2: normalize dividend
  logic  dvv_q [hsi_pkg::DivSteps+1];
  divs_t dv_q  [hsi_pkg::DivSteps+1];
  divs_t dv0_d;
  logic [18:0] sh_a;

  always_comb begin
    dv0_d.k = 4'd8;
    for (int j = 8; j >= 1; j--) begin
      sh_a = 19'(a1_q) << j;
      if (sh_a >= 19'(b1_q)) begin
        dv0_d.k = 4'(j);
      end
    end
    dv0_d.rem = 11'(19'(a1_q) << dv0_d.k);
    dv0_d.b   = b1_q;
    dv0_d.q   = '0;
    dv0_d.sp  = sp1_q;
    dv0_d.spv = spv1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else begin
      dvv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv0_d;
  end

  // one quotient bit per stage
  for (genvar i = 0; i < hsi_pkg::DivSteps; i++) begin : gen_div
    divs_t       nx_d;
    logic        qb;
    logic [10:0] r2;

    always_comb begin
      qb   = dv_q[i].rem >= {1'b0, dv_q[i].b};
      r2   = qb ? dv_q[i].rem - {1'b0, dv_q[i].b} : dv_q[i].rem;
      nx_d = dv_q[i];
      nx_d.rem = {r2[9:0], 1'b0};
      nx_d.q   = {dv_q[i].q[52:0], qb};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[i+1] <= 1'b0;
      end else begin
        dvv_q[i+1] <= dvv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[i+1] <= nx_d;
    end
  end

  // rounding stages
  logic        v_q [5];
  logic [3:0]  k_q;
  logic        sp_q [4];
  logic [7:0]  spv_q [4];
  logic [53:0] mant_q, val1_q, m2_q;
  logic [61:0] v2_q;
  logic [3:0]  sh2_q;
  logic [7:0]  sat_q;

  divs_t       dl;
  logic [52:0] mant;
  logic        up0;
  logic [53:0] mant_d;

  always_comb begin
    dl     = dv_q[hsi_pkg::DivSteps];
    mant   = dl.q[53:1];
    up0    = dl.q[0] && ((dl.rem != 11'd0) || mant[0]);
    mant_d = 54'(mant) + 54'(up0);
  end

  logic [5:0]  f6;
  logic [2:0]  sh3;
  logic [60:0] val, m1, rem1, half1;
  logic        up1;
  logic [53:0] val1_d;

  always_comb begin
    f6    = 6'd52 + 6'(k_q);
    val   = (61'd1 << f6) - 61'(mant_q);
    sh3   = 3'(k_q - 4'd1);
    m1    = val >> sh3;
    rem1  = val & ((61'd1 << sh3) - 61'd1);
    half1 = (sh3 == 3'd0) ? 61'd0 : (61'd1 << (sh3 - 3'd1));
    up1   = (sh3 != 3'd0) && ((rem1 > half1) || ((rem1 == half1) && m1[0]));
    val1_d = 54'(m1 + 61'(up1));
  end

  logic [3:0]  sh2;
  logic [61:0] m2, rem2, half2;
  logic        up2;
  logic [53:0] m2_d;

  always_comb begin
    sh2 = 4'd0;
    for (int t = 53; t <= 61; t++) begin
      if (v2_q[t]) begin
        sh2 = 4'(t - 52);
      end
    end
    m2    = v2_q >> sh2;
    rem2  = v2_q & ((62'd1 << sh2) - 62'd1);
    half2 = (sh2 == 4'd0) ? 62'd0 : (62'd1 << (sh2 - 4'd1));
    up2   = (sh2 != 4'd0) && ((rem2 > half2) || ((rem2 == half2) && m2[0]));
    m2_d  = 54'(m2 + 62'(up2));
  end

  logic [5:0]  shamt;
  logic [53:0] res;

  always_comb begin
    shamt = 6'd53 - 6'(sh2_q);
    res   = m2_q >> shamt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v_q[0] <= dvv_q[hsi_pkg::DivSteps];
      for (int i = 1; i < 5; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q   <= mant_d;
    k_q      <= dl.k;
    sp_q[0]  <= dl.sp;
    spv_q[0] <= dl.spv;
    for (int i = 1; i < 4; i++) begin
      sp_q[i]  <= sp_q[i-1];
      spv_q[i] <= spv_q[i-1];
    end
    val1_q   <= val1_d;
    v2_q     <= {val1_q, 8'b0} - 62'(val1_q);
    m2_q     <= m2_d;
    sh2_q    <= sh2;
    sat_q    <= sp_q[3] ? spv_q[3] : res[7:0];
  end

  assign valid_o = v_q[4];
  assign sat_o   = sat_q;

endmodule

[rtl/rgb_to_hsi_pixel.sv]
// rgb to hsi pixel converter top level: hue and saturation pipelines, intensity path
// depends on hsi_pkg, hsi_hue and hsi_sat
// One pixel is taken on every cycle that start_i is high; busy_o stays low, so a new
// request may follow in the very next cycle. Each request gives one result, shown for
// one cycle with done_o high, in request order. The latency is set by the saturation
// path, which forms its quotient one bit per stage over 54 stages; the hue result,
// found by a seven step search of a 127 entry threshold table, and the intensity are
// delayed to line up with it. The result cannot be held off.
module rgb_to_hsi_pixel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  hsi_pkg::pix_in_t  pixel_i,
  output logic              done_o,
  output hsi_pkg::pix_out_t result_o
);

  logic       req;
  logic       hue_v, sat_v;
  logic [7:0] hue, sat;

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  hsi_hue u_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req),
    .pixel_i (pixel_i),
    .valid_o (hue_v),
    .hue_o   (hue)
  );

  hsi_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req),
    .pixel_i (pixel_i),
    .valid_o (sat_v),
    .sat_o   (sat)
  );

  // intensity by reciprocal multiply
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  int_d;

  always_comb begin
    sum   = 10'(pixel_i.red) + 10'(pixel_i.green) + 10'(pixel_i.blue);
    prod  = 20'(sum) * 20'(hsi_pkg::IntRecip);
    int_d = prod[hsi_pkg::IntShift +: 8];
  end

  logic [7:0] int_q [hsi_pkg::PipeLat];
  logic [7:0] hue_q [hsi_pkg::HueDly];
  logic       hv_q  [hsi_pkg::HueDly];

  always_ff @(posedge clk_i) begin
    int_q[0] <= int_d;
    for (int i = 1; i < hsi_pkg::PipeLat; i++) begin
      int_q[i] <= int_q[i-1];
    end
    hue_q[0] <= hue;
    for (int i = 1; i < hsi_pkg::HueDly; i++) begin
      hue_q[i] <= hue_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hsi_pkg::HueDly; i++) begin
        hv_q[i] <= 1'b0;
      end
    end else begin
      hv_q[0] <= hue_v;
      for (int i = 1; i < hsi_pkg::HueDly; i++) begin
        hv_q[i] <= hv_q[i-1];
      end
    end
  end

  assign done_o              = sat_v && hv_q[hsi_pkg::HueDly-1];
  assign result_o.hue        = hue_q[hsi_pkg::HueDly-1];
  assign result_o.saturation = sat;
  assign result_o.intensity  = int_q[hsi_pkg::PipeLat-1];

endmodule

[rtl/hsi_chk.sv]
// port level checker for the rgb to hsi pixel converter, bound to the top level
// depends on hsi_pkg and rgb_to_hsi_pixel_defines.svh
`include "rgb_to_hsi_pixel_defines.svh"

module hsi_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input hsi_pkg::pix_in_t  pixel_i,
  input logic              done_o,
  input hsi_pkg::pix_out_t result_o
);

  logic grey_req;
  logic neutral;

  assign grey_req = start_i && pixel_i.red == pixel_i.green && pixel_i.green == pixel_i.blue;
  assign neutral  = result_o.hue == 8'd0 && result_o.saturation == 8'd0;

  `HSI_ASSERT_NOW(a_never_busy, 1'b1, !busy_o, "busy raised")
  `HSI_ASSERT_LAT(a_req_done, start_i, done_o, "request without result")
  `HSI_ASSERT_LAT(a_no_extra, !start_i, !done_o, "result without request")
  `HSI_ASSERT_LAT(a_grey, grey_req, neutral, "grey pixel not neutral")

endmodule

bind rgb_to_hsi_pixel hsi_chk u_hsi_chk (.*);

[tb/sv/hsi_result_checker.sv]
// request/result checker for the rgb to hsi pixel converter: predicts each result and compares
// depends on hsi_pkg for the pixel request and result types
module hsi_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  hsi_pkg::pix_in_t  pixel_i,
  input  logic              done_i,
  input  hsi_pkg::pix_out_t result_i,
  output int                errors_o,
  output int                pending_o
);
  import hsi_pkg::*;

  logic [63:0] cos_sq_tab [1:127];
  logic        cos_neg_tab [1:127];
  pix_out_t    expected_q [$];

  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[121:58];
  endfunction

  initial begin
    logic [63:0] num, part, rest, ang, a2, term, mag;
    logic signed [63:0] acc;
    logic [127:0] p;
    for (int k = 1; k <= 127; k++) begin
      num  = 64'(157 * k);
      part = (num << 29) / 64'd6375;
      rest = (num << 29) % 64'd6375;
      ang  = (part << 29) + ((rest << 29) / 64'd6375);
      a2   = fix_mul(ang, ang);
      term = 64'd1 << 58;
      acc  = $signed(term);
      for (int i = 1; i < 40; i++) begin
        term = fix_mul(term, a2) / 64'((2 * i - 1) * (2 * i));
        if (i % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      cos_neg_tab[k] = acc[63];
      mag = acc[63] ? 64'(-acc) : 64'(acc);
      p = 128'(mag) * 128'(mag);
      cos_sq_tab[k] = p[117:54];
    end
  end

  function automatic logic [7:0] predict_hue(int r, int g, int b);
    int x, y, n, dd, cnt;
    logic [127:0] lhs, rhs;
    logic hit;
    x = r - g;
    y = r - b;
    n = (x + y) / 2;
    dd = x * x - x * y + y * y;
    cnt = 0;
    if (dd == 0) return 8'd0;
    lhs = 128'(64'(n * n)) << 62;
    for (int k = 1; k <= 127; k++) begin
      rhs = 128'(cos_sq_tab[k]) * 128'(64'(dd));
      if (n >= 0) hit = !cos_neg_tab[k] && (lhs <= rhs);
      else hit = !cos_neg_tab[k] || (lhs >= rhs);
      if (hit) cnt++;
    end
    return (b <= g) ? 8'(cnt) : 8'(254 - cnt);
  endfunction

  function automatic void round_mant(inout logic [63:0] v, inout int e);
    int sh;
    logic [63:0] m, rem, half;
    sh = 0;
    while ((v >> sh) >= 64'd9007199254740992) sh++;
    if (sh != 0) begin
      m = v >> sh;
      rem = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && m[0])) m++;
      v = m;
      e += sh;
    end
  endfunction

  function automatic logic [7:0] predict_sat(int s, int mn);
    logic [63:0] a, b, rem, q, mant, v;
    int k, f, e;
    if (s == 0) return 8'd0;
    if (mn == 0) return 8'd255;
    a = 64'(3 * mn);
    b = 64'(s);
    if (a >= b) return 8'd0;
    rem = a;
    k = 0;
    q = 0;
    while (rem < b) begin
      rem = rem << 1;
      k++;
    end
    for (int i = 0; i < 54; i++) begin
      q = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q[0] = 1'b1;
      end
      rem = rem << 1;
    end
    mant = q >> 1;
    if (q[0] && (rem != 0 || mant[0])) mant++;
    f = 52 + k;
    v = (64'd1 << f) - mant;
    e = -f;
    round_mant(v, e);
    v = v * 64'd255;
    round_mant(v, e);
    if (e >= 0) return v[7:0];
    if (-e >= 64) return 8'd0;
    return 8'(v >> (-e));
  endfunction

  function automatic pix_out_t predict_pixel(pix_in_t px);
    pix_out_t res;
    int r, g, b, mn, s;
    r = px.red;
    g = px.green;
    b = px.blue;
    mn = b;
    if (mn > g) mn = g;
    if (mn > r) mn = r;
    s = r + g + b;
    res.hue = predict_hue(r, g, b);
    res.saturation = predict_sat(s, mn);
    res.intensity = 8'(s / 3);
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (start_i && !busy_i) expected_q.insert(expected_q.size(), predict_pixel(pixel_i));
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== result_i) begin
            $display("%0t: mismatch, expected hue %0d sat %0d int %0d, actual hue %0d sat %0d int %0d",
                     $time, want.hue, want.saturation, want.intensity,
                     result_i.hue, result_i.saturation, result_i.intensity);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();
endmodule

[tb/sv/tb_rgb_to_hsi_pixel.sv]
// testbench top for the rgb to hsi pixel converter: directed and random pixel requests
// depends on hsi_pkg, rgb_to_hsi_pixel and hsi_result_checker
module tb_rgb_to_hsi_pixel;
  import hsi_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  pix_in_t  pixel_i = '0;
  logic     done_o;
  pix_out_t result_o;
  int       errors;
  int       pending;
  int       cycles = 0;
  int       gap_pct;

  always #5 clk_i = ~clk_i;

  rgb_to_hsi_pixel uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .pixel_i(pixel_i), .done_o(done_o), .result_o(result_o)
  );

  hsi_result_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .pixel_i(pixel_i), .done_i(done_o), .result_i(result_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // idle cycles come with probability of gap_pct percent per cycle
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      pixel_i <= pix_in_t'(24'($urandom));
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    pixel_i <= '{red: r, green: g, blue: b};
    do begin
      @(negedge clk_i);
    end while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin
          v = 8'($urandom);
          send_pixel(v, v, v);
        end
        1: send_pixel(8'($urandom_range(255, 250)), 8'($urandom_range(5)), 8'($urandom_range(255)));
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    gap_pct = 19;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // black, white, greys, primaries, secondaries, zero minimum, blue above and below green
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd1, 8'd2);
    send_pixel(8'd255, 8'd2, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd85, 8'd170, 8'd255);
    send_pixel(8'd100, 8'd50, 8'd50);
    send_random(170);
    gap_pct = 63;
    send_random(160);
    gap_pct = 0;
    send_random(170);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PipeLat + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
